### sv/assert_macros.svh
// assertion macros used by the spin jump detector top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle as its condition
`define ASSERT_IMPLIES(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// property holds in the cycle after its condition
`define ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

### sv/sjd_pkg.sv
// types, constants and the arctangent table of the spin jump detector
`default_nettype none

package sjd_pkg;

    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
    localparam logic signed [16:0] CLAMP_Q13   = 17'sd25736;

    localparam logic [1:0] CFG_ANGLE_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_PERIOD_LIMIT = 2'd1;
    localparam logic [1:0] CFG_FOLLOW_FRAC  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROT,
        ST_WRAP,
        ST_JUMP,
        ST_MUL,
        ST_DEC
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_sts;

    function automatic logic [12:0] atan_q13(input logic [4:0] idx);
        logic [12:0] v;
        case (idx)
            5'd0:    v = 13'd6434;
            5'd1:    v = 13'd3798;
            5'd2:    v = 13'd2007;
            5'd3:    v = 13'd1019;
            5'd4:    v = 13'd511;
            5'd5:    v = 13'd256;
            5'd6:    v = 13'd128;
            5'd7:    v = 13'd64;
            5'd8:    v = 13'd32;
            5'd9:    v = 13'd16;
            5'd10:   v = 13'd8;
            5'd11:   v = 13'd4;
            5'd12:   v = 13'd2;
            5'd13:   v = 13'd1;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/sjd_cordic.sv
// iterative vectoring cordic, one micro-rotation per cycle
`default_nettype none

module sjd_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire logic signed [23:0]   i_x,
    input  wire logic signed [23:0]   i_y,
    output sjd_pkg::t_cordic_sts      o_sts,
    output logic signed [15:0]        o_yaw
);
    import sjd_pkg::*;

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic signed [34:0] r_cx, r_cy;
    logic signed [16:0] r_z;
    logic [IW-1:0]      r_iter;
    logic               r_busy, r_done, r_zero;

    logic signed [34:0] x0, y0, n_cx, n_cy, dx, dy;
    logic signed [16:0] z0, n_z, ang, zc;

    always_comb begin
        x0 = {{3{i_x[23]}}, i_x, 8'd0};
        y0 = {{3{i_y[23]}}, i_y, 8'd0};
        z0 = '0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                z0 = HALF_PI_Q13;
                n_cx = y0;
                n_cy = -x0;
            end else begin
                z0 = -HALF_PI_Q13;
                n_cx = -y0;
                n_cy = x0;
            end
        end else begin
            n_cx = x0;
            n_cy = y0;
        end
    end

    always_comb begin
        dx  = r_cy >>> r_iter;
        dy  = r_cx >>> r_iter;
        ang = {4'd0, atan_q13(5'(r_iter))};
        n_z = (r_cy > 0) ? r_z + ang : r_z - ang;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
                r_cx   <= n_cx;
                r_cy   <= n_cy;
                r_z    <= z0;
                r_zero <= (i_x == 24'sd0) && (i_y == 24'sd0);
            end else if (r_busy) begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + dx;
                    r_cy <= r_cy - dy;
                end else begin
                    r_cx <= r_cx - dx;
                    r_cy <= r_cy + dy;
                end
                r_z    <= n_z;
                r_iter <= r_iter + 1'b1;
                if (r_iter == IW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_z > CLAMP_Q13) begin
            zc = CLAMP_Q13;
        end else if (r_z < -CLAMP_Q13) begin
            zc = -CLAMP_Q13;
        end else begin
            zc = r_z;
        end
        o_yaw      = r_zero ? 16'sd0 : 16'(zc);
        o_sts.busy = r_busy;
        o_sts.done = r_done;
    end

endmodule

`default_nettype wire

### sv/spin_jump_detector.sv
// spin jump detector top level: sequencer, tracking state and result register
// tracked word: prep, cordic rotation, wrap, jump, multiply, decide; untracked word: prep, multiply, decide
// one word at a time; a tracked word also waits on the iterative cordic
// a new word is taken once the previous one has reached the result register
// synchronous active-low reset clears spin state, counters, the last jump stamp and config
// config registers reset to angle 3277, period 800000 us, follow 128
`default_nettype none
`include "assert_macros.svh"

module spin_jump_detector #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_stall,
    input  wire logic [31:0]          i_stamp_us,
    input  wire                       i_tracking,
    input  wire logic signed [23:0]   i_pos_x,
    input  wire logic signed [23:0]   i_pos_y,
    input  wire logic signed [23:0]   i_pos_z,
    input  wire logic signed [23:0]   i_vel_x,
    input  wire logic signed [23:0]   i_vel_y,
    input  wire logic signed [23:0]   i_vel_z,
    output logic                      o_valid,
    input  wire                       i_stall,
    output logic signed [23:0]        o_out_pos_x,
    output logic signed [23:0]        o_out_pos_y,
    output logic signed [23:0]        o_out_pos_z,
    output logic signed [23:0]        o_out_vel_x,
    output logic signed [23:0]        o_out_vel_y,
    output logic signed [23:0]        o_out_vel_z,
    output logic                      o_fire_hint,
    output logic                      o_spinning,
    output logic [7:0]                o_jumps_seen,
    output logic signed [15:0]        o_yaw_step,
    output logic [31:0]               o_period_us,
    output logic [31:0]               o_since_jump_us,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);
    import sjd_pkg::*;

    t_state r_state, n_state;

    // config
    logic [14:0] r_angle_limit;
    logic [31:0] r_period_limit;
    logic [15:0] r_follow;

    // spin state
    logic               r_spin, r_last_neg;
    logic [7:0]         r_count;
    logic [31:0]        r_period, r_last_stamp;
    logic signed [23:0] r_jpos [3];
    logic signed [15:0] r_prev_yaw;

    // captured word and working values
    logic [31:0]        r_stamp, r_since;
    logic               r_trk;
    logic signed [23:0] r_pos [3];
    logic signed [23:0] r_vel [3];
    logic signed [15:0] r_step;
    logic [47:0]        r_rhs;

    // result register
    logic               r_out_valid, r_fire, r_ospin;
    logic signed [23:0] r_opos [3];
    logic signed [23:0] r_ovel [3];
    logic [7:0]         r_ocount;
    logic signed [15:0] r_ostep;
    logic [31:0]        r_operiod, r_osince;

    logic               in_acc, out_free, cor_start;
    logic [31:0]        since;
    logic signed [15:0] yaw, mag;
    logic signed [17:0] d, dw;
    logic [7:0]         n_count;
    logic               neg, hold;
    t_cordic_sts        cor_sts;

    sjd_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_x     (r_pos[0]),
        .i_y     (r_pos[1]),
        .o_sts   (cor_sts),
        .o_yaw   (yaw)
    );

    assign o_stall     = (r_state != ST_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        cor_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                cor_start = r_trk;
                n_state   = r_trk ? ST_ROT : ST_MUL;
            end
            ST_ROT: begin
                if (cor_sts.done) begin
                    n_state = ST_WRAP;
                end
            end
            ST_WRAP: n_state = ST_JUMP;
            ST_JUMP: n_state = ST_MUL;
            ST_MUL:  n_state = ST_DEC;
            ST_DEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        since = r_stamp - r_last_stamp;
        d     = {{2{yaw[15]}}, yaw} - {{2{r_prev_yaw[15]}}, r_prev_yaw};
        if (d >= PI_Q13) begin
            dw = d - TWO_PI_Q13;
        end else if (d < -PI_Q13) begin
            dw = d + TWO_PI_Q13;
        end else begin
            dw = d;
        end
        neg     = r_step[15];
        mag     = neg ? -r_step : r_step;
        n_count = (r_count == 8'hff) ? r_count : r_count + 8'd1;
        hold    = r_spin && !({8'd0, r_since, 8'd0} < r_rhs);
    end

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_limit  <= 15'd3277;
            r_period_limit <= 32'd800000;
            r_follow       <= 16'd128;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ANGLE_LIMIT:  r_angle_limit  <= i_cfg_data[14:0];
                CFG_PERIOD_LIMIT: r_period_limit <= i_cfg_data;
                CFG_FOLLOW_FRAC:  r_follow       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // captured word and working values
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_stamp  <= i_stamp_us;
            r_trk    <= i_tracking;
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            r_vel[0] <= i_vel_x;
            r_vel[1] <= i_vel_y;
            r_vel[2] <= i_vel_z;
        end
        if (r_state == ST_PREP) begin
            r_since <= since;
            r_step  <= 16'sd0;
        end
        if (r_state == ST_WRAP) begin
            r_step <= 16'(dw);
        end
        if (r_state == ST_MUL) begin
            r_rhs <= r_follow * r_period;
        end
    end

    // spin state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin       <= 1'b0;
            r_last_neg   <= 1'b0;
            r_count      <= 8'd0;
            r_period     <= 32'd0;
            r_last_stamp <= 32'd0;
            r_prev_yaw   <= 16'sd0;
            r_jpos[0]    <= 24'sd0;
            r_jpos[1]    <= 24'sd0;
            r_jpos[2]    <= 24'sd0;
        end else begin
            if (r_state == ST_PREP && since > r_period_limit) begin
                r_spin  <= 1'b0;
                r_count <= 8'd0;
            end
            if (r_state == ST_JUMP) begin
                r_prev_yaw <= yaw;
                if ($unsigned(mag) > {1'b0, r_angle_limit}) begin
                    r_count <= n_count;
                    if (n_count > 8'd1 && neg == r_last_neg) begin
                        r_spin   <= 1'b1;
                        r_period <= r_since;
                    end
                    r_last_stamp <= r_stamp;
                    r_jpos[0]    <= r_pos[0];
                    r_jpos[1]    <= r_pos[1];
                    r_jpos[2]    <= r_pos[2];
                    r_last_neg   <= neg;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DEC && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DEC && out_free) begin
            for (int k = 0; k < 3; k++) begin
                r_opos[k] <= hold ? r_jpos[k] : r_pos[k];
                r_ovel[k] <= hold ? 24'sd0 : r_vel[k];
            end
            r_fire    <= r_spin ? !hold : r_trk;
            r_ospin   <= r_spin;
            r_ocount  <= r_count;
            r_ostep   <= r_step;
            r_operiod <= r_period;
            r_osince  <= r_since;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_pos_x     = r_opos[0];
    assign o_out_pos_y     = r_opos[1];
    assign o_out_pos_z     = r_opos[2];
    assign o_out_vel_x     = r_ovel[0];
    assign o_out_vel_y     = r_ovel[1];
    assign o_out_vel_z     = r_ovel[2];
    assign o_fire_hint     = r_fire;
    assign o_spinning      = r_ospin;
    assign o_jumps_seen    = r_ocount;
    assign o_yaw_step      = r_ostep;
    assign o_period_us     = r_operiod;
    assign o_since_jump_us = r_osince;

    `ASSERT_IMPLIES(a_cordic_in_rot, cor_sts.busy || cor_sts.done, r_state == ST_ROT)
    `ASSERT_IMPLIES(a_spin_count, o_valid && o_spinning, o_jumps_seen >= 8'd2)
    `ASSERT_IMPLIES(a_hold_zero_vel, o_valid && o_spinning && !o_fire_hint, (o_out_vel_x == 24'sd0) && (o_out_vel_y == 24'sd0) && (o_out_vel_z == 24'sd0))
    `ASSERT_NEXT(a_accept_prep, in_acc, r_state == ST_PREP)

endmodule

`default_nettype wire
